// ===== rtl/indexed_max_heap_queue_assert.svh =====
// ----------------------------------------------------------------------------
// indexed max-heap queue assertion macros
// concurrent assertion helpers, empty when synthesized
// ----------------------------------------------------------------------------
`ifndef INDEXED_MAX_HEAP_QUEUE_ASSERT_SVH
`define INDEXED_MAX_HEAP_QUEUE_ASSERT_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define IMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// expression must never be true out of reset
`define IMHQ_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);
`else
`define IMHQ_ASSERT(lbl, prop, msg)
`define IMHQ_NEVER(lbl, expr, msg)
`endif
`endif

// ===== rtl/imhq_pkg.sv =====
// ----------------------------------------------------------------------------
// imhq_pkg
// shared types and codes of the indexed max-heap queue
// ----------------------------------------------------------------------------
`default_nettype none
package imhq_pkg;

  localparam logic [1:0] FN_PUSH = 2'd0;
  localparam logic [1:0] FN_POP  = 2'd1;
  localparam logic [1:0] FN_INC  = 2'd2;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_FULL   = 3'd1,
    ST_EMPTY  = 3'd2,
    ST_ABSENT = 3'd3,
    ST_DUP    = 3'd4
  } status_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  key;
    logic [31:0] amount;
  } imhq_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  front_key;
    logic [31:0] front_priority;
    logic [8:0]  entry_count;
    logic        is_empty;
  } imhq_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic clr;
    logic capture;
    logic decide;
    logic inc_item;
    logic up_read;
    logic up_step;
    logic place;
    logic pop_last;
    logic dn_read;
    logic dn_step;
    logic result_load;
  } imhq_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_push;
    logic is_pop;
    logic is_inc;
    logic push_go;
    logic pop_go;
    logic pop_more;
    logic inc_go;
    logic up_at_root;
    logic up_next_root;
    logic up_swap;
    logic dn_leaf;
    logic dn_swap;
    logic clear_done;
    logic out_free;
  } imhq_stat_t;

endpackage
`default_nettype wire

// ===== rtl/imhq_dpath.sv =====
// ----------------------------------------------------------------------------
// imhq_dpath
// heap and key map memories, sift registers, compare logic, result register
// ----------------------------------------------------------------------------
`default_nettype none
module imhq_dpath #(
  parameter int CAPACITY      = 256,
  parameter int KEY_SPACE     = 256,
  parameter int PRIORITY_BITS = 32
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  imhq_pkg::imhq_req_t   req_i,
  input  imhq_pkg::imhq_cmd_t   cmd_i,
  output imhq_pkg::imhq_stat_t  stat_o,
  input  wire                   rsp_ready_i,
  output logic                  rsp_valid_o,
  output imhq_pkg::imhq_rsp_t   rsp_o
);
  import imhq_pkg::*;

  localparam int PW  = $clog2(CAPACITY + 1);
  localparam int KIW = (KEY_SPACE > 1) ? $clog2(KEY_SPACE) : 1;
  localparam logic [63:0] PRIO_MAX =
    (PRIORITY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << PRIORITY_BITS) - 64'd1);

  typedef struct packed {
    logic [7:0]               key;
    logic [PRIORITY_BITS-1:0] prio;
  } entry_t;

  entry_t          heap_mem [CAPACITY+1];
  logic [PW-1:0]   kp_mem   [KEY_SPACE];

  logic [1:0]               func_q;
  logic [7:0]               key_q;
  logic [PRIORITY_BITS-1:0] amt_q;
  logic [PW-1:0]            pos_q;
  entry_t                   item_q;
  logic [PW-1:0]            count_q;
  logic [KIW-1:0]           clr_idx_q;
  status_e                  status_q;
  entry_t                   rd_a_q, rd_b_q;
  logic [PW-1:0]            kp_rd_q;
  imhq_rsp_t                rsp_q;
  logic                     rsp_valid_q;

  logic [63:0]              amt_wide;
  logic [PRIORITY_BITS-1:0] amt_clamp;
  logic [PRIORITY_BITS:0]   sat_sum;
  logic                     in_space;
  logic [PW:0]              two_pos, two_pos1;
  logic                     right_ok;
  entry_t                   child;
  logic [PW-1:0]            child_idx;
  logic [PW-1:0]            addr_a, addr_b;
  logic                     kp_we;
  logic [KIW-1:0]           kp_waddr;
  logic [PW-1:0]            kp_wdata;
  logic                     heap_we;
  entry_t                   heap_wdata;

  // amount clamped to the priority range
  assign amt_wide  = 64'(req_i.amount);
  assign amt_clamp = PRIORITY_BITS'((amt_wide > PRIO_MAX) ? PRIO_MAX : amt_wide);
  assign sat_sum   = {1'b0, rd_a_q.prio} + {1'b0, amt_q};

  assign in_space  = int'(key_q) < KEY_SPACE;
  assign two_pos   = {pos_q, 1'b0};
  assign two_pos1  = two_pos + (PW+1)'(1);
  assign right_ok  = (two_pos1 <= {1'b0, count_q}) && (rd_b_q.prio > rd_a_q.prio);
  assign child     = right_ok ? rd_b_q : rd_a_q;
  assign child_idx = right_ok ? two_pos1[PW-1:0] : two_pos[PW-1:0];

  always_comb begin
    stat_o.is_push      = func_q == FN_PUSH;
    stat_o.is_pop       = func_q == FN_POP;
    stat_o.is_inc       = func_q == FN_INC;
    stat_o.push_go      = in_space && (kp_rd_q == '0) && (int'(count_q) < CAPACITY);
    stat_o.pop_go       = count_q != '0;
    stat_o.pop_more     = count_q > PW'(1);
    stat_o.inc_go       = in_space && (kp_rd_q != '0) && (kp_rd_q <= count_q);
    stat_o.up_at_root   = pos_q == PW'(1);
    stat_o.up_next_root = pos_q[PW-1:1] == (PW-1)'(1);
    stat_o.up_swap      = rd_a_q.prio < item_q.prio;
    stat_o.dn_leaf      = two_pos > {1'b0, count_q};
    stat_o.dn_swap      = !(item_q.prio > child.prio);
    stat_o.clear_done   = clr_idx_q == KIW'(KEY_SPACE - 1);
    stat_o.out_free     = !rsp_valid_q || rsp_ready_i;
  end

  // read addresses, root by default
  always_comb begin
    addr_a = PW'(1);
    addr_b = count_q;
    if (cmd_i.decide && stat_o.is_inc) begin
      addr_a = kp_rd_q;
    end else if (cmd_i.up_read) begin
      addr_a = pos_q >> 1;
    end else if (cmd_i.up_step) begin
      addr_a = pos_q >> 2;
    end else if (cmd_i.dn_read) begin
      addr_a = two_pos[PW-1:0];
      addr_b = two_pos1[PW-1:0];
    end
  end

  always_comb begin
    kp_we    = 1'b0;
    kp_waddr = KIW'(item_q.key);
    kp_wdata = pos_q;
    if (cmd_i.clr) begin
      kp_we    = 1'b1;
      kp_waddr = clr_idx_q;
      kp_wdata = '0;
    end else if (cmd_i.decide && stat_o.is_pop && stat_o.pop_go) begin
      kp_we    = 1'b1;
      kp_waddr = KIW'(rd_a_q.key);
      kp_wdata = '0;
    end else if (cmd_i.up_step) begin
      kp_we    = 1'b1;
      kp_waddr = KIW'(rd_a_q.key);
    end else if (cmd_i.dn_step) begin
      kp_we    = 1'b1;
      kp_waddr = KIW'(child.key);
    end else if (cmd_i.place) begin
      kp_we    = 1'b1;
    end
  end

  assign heap_we    = cmd_i.up_step || cmd_i.dn_step || cmd_i.place;
  assign heap_wdata = cmd_i.place ? item_q : (cmd_i.up_step ? rd_a_q : child);

  always_ff @(posedge clk_i) begin
    if (heap_we) begin
      heap_mem[pos_q] <= heap_wdata;
    end
    rd_a_q <= heap_mem[addr_a];
    rd_b_q <= heap_mem[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (kp_we) begin
      kp_mem[kp_waddr] <= kp_wdata;
    end
    kp_rd_q <= kp_mem[KIW'(req_i.key)];
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q <= req_i.func;
      key_q  <= req_i.key;
      amt_q  <= amt_clamp;
    end
    if (cmd_i.decide) begin
      if (stat_o.is_push) begin
        if (!in_space)                   status_q <= ST_ABSENT;
        else if (kp_rd_q != '0)          status_q <= ST_DUP;
        else if (!stat_o.push_go)        status_q <= ST_FULL;
        else                             status_q <= ST_OK;
        pos_q       <= count_q + PW'(1);
        item_q.key  <= key_q;
        item_q.prio <= amt_q;
      end else if (stat_o.is_pop) begin
        status_q <= stat_o.pop_go ? ST_OK : ST_EMPTY;
      end else if (stat_o.is_inc) begin
        status_q <= stat_o.inc_go ? ST_OK : ST_ABSENT;
        pos_q    <= kp_rd_q;
      end else begin
        status_q <= ST_OK;
      end
    end
    if (cmd_i.inc_item) begin
      item_q.key  <= rd_a_q.key;
      item_q.prio <= sat_sum[PRIORITY_BITS] ? {PRIORITY_BITS{1'b1}}
                                            : sat_sum[PRIORITY_BITS-1:0];
    end
    if (cmd_i.pop_last) begin
      item_q <= rd_b_q;
      pos_q  <= PW'(1);
    end
    if (cmd_i.up_step) begin
      pos_q <= pos_q >> 1;
    end
    if (cmd_i.dn_step) begin
      pos_q <= child_idx;
    end
    if (cmd_i.result_load) begin
      rsp_q.status         <= status_q;
      rsp_q.front_key      <= (count_q != '0) ? rd_a_q.key : 8'd0;
      rsp_q.front_priority <= (count_q != '0) ? 32'(rd_a_q.prio) : 32'd0;
      rsp_q.entry_count    <= 9'(count_q);
      rsp_q.is_empty       <= count_q == '0;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      clr_idx_q   <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_i.decide && stat_o.is_push && stat_o.push_go) begin
        count_q <= count_q + PW'(1);
      end else if (cmd_i.decide && stat_o.is_pop && stat_o.pop_go) begin
        count_q <= count_q - PW'(1);
      end
      if (cmd_i.clr) begin
        clr_idx_q <= clr_idx_q + KIW'(1);
      end
      if (cmd_i.result_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule
`default_nettype wire

// ===== rtl/imhq_ctrl.sv =====
// ----------------------------------------------------------------------------
// imhq_ctrl
// sequencer for clearing, decode, sift-up, sift-down and result hand-off
// ----------------------------------------------------------------------------
`default_nettype none
`include "indexed_max_heap_queue_assert.svh"
module imhq_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   req_valid_i,
  output logic                  req_ready_o,
  input  imhq_pkg::imhq_stat_t  stat_i,
  output imhq_pkg::imhq_cmd_t   cmd_o
);
  import imhq_pkg::*;

  typedef enum logic [11:0] {
    S_CLEAR    = 12'b000000000001,
    S_IDLE     = 12'b000000000010,
    S_LOOK     = 12'b000000000100,
    S_INC      = 12'b000000001000,
    S_UP_RD    = 12'b000000010000,
    S_UP_CMP   = 12'b000000100000,
    S_PLACE    = 12'b000001000000,
    S_POP_LAST = 12'b000010000000,
    S_DN_RD    = 12'b000100000000,
    S_DN_CMP   = 12'b001000000000,
    S_ROOT     = 12'b010000000000,
    S_RES      = 12'b100000000000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (stat_i.clear_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd_o.decide = 1'b1;
        state_d      = S_ROOT;
        if (stat_i.is_push && stat_i.push_go) begin
          state_d = S_UP_RD;
        end else if (stat_i.is_pop && stat_i.pop_go && stat_i.pop_more) begin
          state_d = S_POP_LAST;
        end else if (stat_i.is_inc && stat_i.inc_go) begin
          state_d = S_INC;
        end
      end
      S_INC: begin
        cmd_o.inc_item = 1'b1;
        state_d        = S_UP_RD;
      end
      S_UP_RD: begin
        if (stat_i.up_at_root) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.up_read = 1'b1;
          state_d       = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        if (stat_i.up_swap) begin
          cmd_o.up_step = 1'b1;
          if (stat_i.up_next_root) state_d = S_PLACE;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        cmd_o.place = 1'b1;
        state_d     = S_ROOT;
      end
      S_POP_LAST: begin
        cmd_o.pop_last = 1'b1;
        state_d        = S_DN_RD;
      end
      S_DN_RD: begin
        if (stat_i.dn_leaf) begin
          state_d = S_PLACE;
        end else begin
          cmd_o.dn_read = 1'b1;
          state_d       = S_DN_CMP;
        end
      end
      S_DN_CMP: begin
        if (stat_i.dn_swap) begin
          cmd_o.dn_step = 1'b1;
          state_d       = S_DN_RD;
        end else begin
          state_d = S_PLACE;
        end
      end
      S_ROOT: begin
        state_d = S_RES;
      end
      S_RES: begin
        if (stat_i.out_free) begin
          cmd_o.result_load = 1'b1;
          state_d           = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  `IMHQ_ASSERT(a_accept_to_look, (req_valid_i && req_ready_o) |=> (state_q == S_LOOK), "accepted request did not go to decode")
  `IMHQ_NEVER(a_load_when_busy, cmd_o.result_load && !stat_i.out_free, "result loaded over a waiting result")
  `IMHQ_ASSERT(a_sift_stop_places, (cmd_o.place) |=> (state_q == S_ROOT), "placement not followed by root read")

endmodule
`default_nettype wire

// ===== rtl/indexed_max_heap_queue.sv =====
// ----------------------------------------------------------------------------
// indexed max-heap queue
// priority queue with push, pop front and increase key over a binary heap
// ----------------------------------------------------------------------------
// usage
// - request channel (req_valid_i / req_ready_o / req_i) carries func, key and
//   amount; one request is worked on at a time
// - response channel (rsp_valid_o / rsp_ready_i / rsp_o) returns one response
//   per request: status, front key and priority, entry count, empty flag
// - the response sits in an output register; the next request is accepted
//   while it waits, and the sequencer holds before loading a new response
//   until the receiver takes the old one
// - after reset the key map is cleared, one entry per cycle, over all KEY_SPACE
//   entries; req_ready_o stays low during this pass
// ----------------------------------------------------------------------------
`default_nettype none
module indexed_max_heap_queue #(
  parameter int CAPACITY      = 256,
  parameter int KEY_SPACE     = 256,
  parameter int PRIORITY_BITS = 32
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  output logic                 req_ready_o,
  input  imhq_pkg::imhq_req_t  req_i,
  output logic                 rsp_valid_o,
  input  wire                  rsp_ready_i,
  output imhq_pkg::imhq_rsp_t  rsp_o
);
  import imhq_pkg::*;

  // command and status between sequencer and datapath
  imhq_cmd_t  cmd;
  imhq_stat_t stat;

  // sequencer: clearing pass, decode, sift loops, response hand-off
  imhq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // datapath: heap memory, key map, compare and saturating add
  imhq_dpath #(
    .CAPACITY      (CAPACITY),
    .KEY_SPACE     (KEY_SPACE),
    .PRIORITY_BITS (PRIORITY_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .rsp_ready_i (rsp_ready_i),
    .rsp_valid_o (rsp_valid_o),
    .rsp_o       (rsp_o)
  );

endmodule
`default_nettype wire

// ===== verif/imhq_checker.sv =====
// ----------------------------------------------------------------------------
// imhq_checker
// watches both channels of the heap queue, predicts each response, compares
// ----------------------------------------------------------------------------
module imhq_checker (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  req_valid_i,
  input  wire                  req_ready_i,
  input  imhq_pkg::imhq_req_t  req_i,
  input  wire                  rsp_valid_i,
  input  wire                  rsp_ready_i,
  input  imhq_pkg::imhq_rsp_t  rsp_i,
  output int                   fail_count_o,
  output int                   pending_o
);
  import imhq_pkg::*;

  localparam int CAP = 256;

  logic [7:0]  heap_key [1:CAP];
  logic [31:0] heap_prio [1:CAP];
  logic [8:0]  key_pos [0:255];
  int          fill;
  imhq_rsp_t   rsp_queue [$];

  initial begin
    fill = 0;
    fail_count_o = 0;
    for (int i = 0; i < 256; i++) key_pos[i] = '0;
  end

  assign pending_o = rsp_queue.size();

  function automatic void swap_at(int a, int b);
    logic [7:0]  k;
    logic [31:0] p;
    k = heap_key[a];  p = heap_prio[a];
    heap_key[a] = heap_key[b];  heap_prio[a] = heap_prio[b];
    heap_key[b] = k;  heap_prio[b] = p;
    key_pos[heap_key[a]] = 9'(a);
    key_pos[heap_key[b]] = 9'(b);
  endfunction

  function automatic void bubble_up(int pos);
    while (pos > 1 && heap_prio[pos / 2] < heap_prio[pos]) begin
      swap_at(pos / 2, pos);
      pos = pos / 2;
    end
  endfunction

  function automatic void bubble_down(int pos);
    int c;
    while (2 * pos <= fill) begin
      c = 2 * pos;
      if (c + 1 <= fill && heap_prio[c + 1] > heap_prio[c]) c++;
      if (heap_prio[pos] > heap_prio[c]) break;
      swap_at(pos, c);
      pos = c;
    end
  endfunction

  function automatic imhq_rsp_t apply_request(imhq_req_t r);
    imhq_rsp_t  o;
    status_e    st;
    int         pos;
    logic [32:0] sum;
    st = ST_OK;
    if (r.func == FN_PUSH) begin
      if (key_pos[r.key] != 0) st = ST_DUP;
      else if (fill >= CAP) st = ST_FULL;
      else begin
        fill++;
        heap_key[fill] = r.key;
        heap_prio[fill] = r.amount;
        key_pos[r.key] = 9'(fill);
        bubble_up(fill);
      end
    end else if (r.func == FN_POP) begin
      if (fill == 0) st = ST_EMPTY;
      else begin
        key_pos[heap_key[1]] = '0;
        if (fill > 1) begin
          heap_key[1] = heap_key[fill];
          heap_prio[1] = heap_prio[fill];
          key_pos[heap_key[1]] = 9'd1;
        end
        fill--;
        bubble_down(1);
      end
    end else if (r.func == FN_INC) begin
      pos = key_pos[r.key];
      if (pos == 0 || pos > fill) st = ST_ABSENT;
      else begin
        sum = {1'b0, heap_prio[pos]} + {1'b0, r.amount};
        heap_prio[pos] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
        bubble_up(pos);
      end
    end
    o.status = st;
    o.front_key = fill != 0 ? heap_key[1] : '0;
    o.front_priority = fill != 0 ? heap_prio[1] : '0;
    o.entry_count = 9'(fill);
    o.is_empty = fill == 0;
    return o;
  endfunction

  always @(posedge clk_i) begin
    imhq_rsp_t want;
    imhq_rsp_t nxt;
    if (rst_ni) begin
      if (req_valid_i && req_ready_i) begin
        nxt = apply_request(req_i);
        rsp_queue.insert(rsp_queue.size(), nxt);
      end
      if (rsp_valid_i && rsp_ready_i) begin
        if (rsp_queue.size() == 0) begin
          $display("%0t: unexpected response %h", $time, rsp_i);
          fail_count_o++;
        end else begin
          want = rsp_queue[0];
          rsp_queue.delete(0);
          if (rsp_i.status !== want.status ||
              rsp_i.front_key !== want.front_key ||
              rsp_i.front_priority !== want.front_priority ||
              rsp_i.entry_count !== want.entry_count ||
              rsp_i.is_empty !== want.is_empty) begin
            $display("%0t: response mismatch expected %h actual %h", $time, want, rsp_i);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// drives push, pop and increase-key requests into the heap queue with random
// gaps and stalls; the checker predicts and compares every response
// ----------------------------------------------------------------------------
module testbench;
  import imhq_pkg::*;

  localparam int LIMIT = 400000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      req_valid = 1'b0;
  logic      req_ready;
  imhq_req_t req = '0;
  logic      rsp_valid;
  logic      rsp_ready = 1'b0;
  imhq_rsp_t rsp;
  int        fail_count;
  int        pending;
  int        cycle = 0;
  bit        no_gaps = 1'b0;
  bit        hold_off = 1'b0;
  bit        stim_done = 1'b0;
  logic [7:0] live_keys [$];

  always #2 clk = ~clk;

  indexed_max_heap_queue u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_ready_o(req_ready), .req_i(req),
    .rsp_valid_o(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_o(rsp)
  );

  imhq_checker u_checker (
    .clk_i(clk), .rst_ni(rst_n),
    .req_valid_i(req_valid), .req_ready_i(req_ready), .req_i(req),
    .rsp_valid_i(rsp_valid), .rsp_ready_i(rsp_ready), .rsp_i(rsp),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // watchdog
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off, none near the end
  initial begin
    int n;
    repeat (10) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        rsp_ready <= 1'b0;
        wait (!hold_off);
      end else if (!no_gaps && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 17);
        rsp_ready <= 1'b0;
        repeat (n) @(negedge clk);
        rsp_ready <= 1'b1;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // one request, held until accepted; valid stays high between requests
  // sent back to back
  task automatic send(logic [1:0] fn, logic [7:0] k, logic [31:0] amt);
    int n;
    if (!no_gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 17);
      req_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    req_valid <= 1'b1;
    req <= '{func: fn, key: k, amount: amt};
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  // random request biased toward keys already held
  task automatic random_request(int push_weight);
    int         r;
    logic [7:0] k;
    logic [31:0] a;
    r = $urandom_range(0, 99);
    a = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 40);
    if (live_keys.size() != 0 && $urandom_range(0, 3) != 0)
      k = live_keys[$urandom_range(0, live_keys.size() - 1)];
    else
      k = 8'($urandom);
    if (r < push_weight) begin
      send(FN_PUSH, k, a);
      live_keys.insert(live_keys.size(), k);
    end else if (r < push_weight + 25) begin
      send(FN_POP, 8'($urandom), $urandom);
    end else begin
      send(FN_INC, k, a);
    end
    if (live_keys.size() > 300) live_keys.delete(0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: empty pop, extremes, equal priorities, saturation, errors
    send(FN_POP, 8'h00, 32'h0);
    send(FN_INC, 8'h05, 32'h1);
    send(FN_PUSH, 8'h00, 32'h0);
    send(FN_PUSH, 8'hFF, 32'hFFFF_FFFF);
    send(FN_PUSH, 8'h00, 32'h5);
    send(FN_PUSH, 8'h55, 32'h0000_0100);
    send(FN_PUSH, 8'hAA, 32'h0000_0100);
    send(FN_PUSH, 8'h0F, 32'h0000_0100);
    send(FN_INC, 8'h00, 32'hFFFF_FFFF);
    send(FN_INC, 8'hFF, 32'h1);
    send(FN_INC, 8'h55, 32'h0);
    send(FN_PUSH, 8'hF0, 32'hAAAA_5555);
    for (int i = 0; i < 7; i++) send(FN_POP, 8'hFF, 32'h0);
    send(FN_PUSH, 8'h3C, 32'h5555_AAAA);
    send(FN_POP, 8'h00, 32'hFFFF_FFFF);

    // fill to capacity then push a held key twice; receiver holds off meanwhile
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < 256; i++) send(FN_PUSH, 8'(i), $urandom_range(0, 300));
    send(FN_PUSH, 8'h80, 32'h7);
    send(FN_PUSH, 8'h80, 32'h7);
    for (int i = 0; i < 10; i++) send(FN_INC, 8'($urandom), $urandom_range(0, 500));
    for (int i = 0; i < 50; i++) send(FN_POP, 8'h0, 32'h0);

    // random mix in three phases of push weight, the last without gaps
    for (int i = 0; i < 25; i++) random_request(55);
    for (int i = 0; i < 20; i++) random_request(25);
    no_gaps = 1'b1;
    for (int i = 0; i < 20; i++) random_request(40);
    req_valid <= 1'b0;

    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

// ===== indexed_max_heap_queue.f =====
+incdir+rtl
rtl/imhq_pkg.sv
rtl/imhq_dpath.sv
rtl/imhq_ctrl.sv
rtl/indexed_max_heap_queue.sv
verif/imhq_checker.sv
verif/testbench.sv
